// ===== hw/rtl/multilevel_min_max_peak_pyramid_defines.svh =====
// Assertion macros for the peak pyramid RTL.
`ifndef MULTILEVEL_MIN_MAX_PEAK_PYRAMID_DEFINES_SVH
`define MULTILEVEL_MIN_MAX_PEAK_PYRAMID_DEFINES_SVH

`ifndef ASSERT_OFF
`define MMPP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MMPP_NEVER(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define MMPP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MMPP_NEVER(lbl, clk, rst_n, prop, msg)
`endif

`endif

// ===== hw/rtl/mmpp_pkg.sv =====
`timescale 1ns / 1ps

package mmpp_pkg;

    localparam int LEVELS = 16;
    localparam int SMP_W  = 16;
    localparam int CNT_W  = 32;
    localparam int LVL_W  = 5;
    localparam int IDX_W  = 31;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [LVL_W-1:0]        level;
        logic [IDX_W-1:0]        block_index;
        logic signed [SMP_W-1:0] low_peak;
        logic signed [SMP_W-1:0] high_peak;
        logic                    run_end;
    } t_rec;

    typedef struct packed {
        logic busy;
        logic extra;
        logic aligned;
    } t_up;

endpackage

// ===== hw/rtl/mmpp_cell.sv =====
`timescale 1ns / 1ps
`include "multilevel_min_max_peak_pyramid_defines.svh"

module mmpp_cell import mmpp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [LVL_W-1:0]        i_level,
    input  logic                    i_accept,
    input  logic signed [SMP_W-1:0] i_sample,
    input  logic                    i_last,
    input  logic                    i_move,
    input  logic [CNT_W-1:0]        i_cnt,
    output logic [CNT_W-1:0]        o_cnt,
    input  t_up                     i_up,
    output t_up                     o_up,
    input  logic                    i_above,
    output logic                    o_above,
    input  t_rec                    i_pick,
    output t_rec                    o_pick
);

    logic signed [SMP_W-1:0] r_min, n_min;
    logic signed [SMP_W-1:0] r_max, n_max;
    logic                    r_partial, n_partial;
    logic [IDX_W-1:0]        r_count, n_count;
    logic                    r_slot_valid, n_slot_valid;
    t_rec                    r_slot, n_slot;

    logic signed [SMP_W-1:0] fold_min;
    logic signed [SMP_W-1:0] fold_max;
    logic                    aligned;
    logic                    flush;
    logic                    emit;
    logic                    sel;
    t_rec                    rec;

    always_comb begin
        fold_min = (r_partial && r_min < i_sample) ? r_min : i_sample;
        fold_max = (r_partial && r_max > i_sample) ? r_max : i_sample;
        aligned  = i_up.aligned & ~i_cnt[0];
        o_cnt    = i_cnt >> 1;
        flush    = i_last & (|o_cnt);
        emit     = aligned | flush;
        sel      = r_slot_valid & ~i_up.busy;

        o_up.busy    = i_up.busy | r_slot_valid;
        o_up.extra   = i_up.extra | (r_slot_valid & i_up.busy);
        o_up.aligned = aligned;
        o_above      = i_above | emit;
        o_pick       = sel ? r_slot : i_pick;

        rec.level       = i_level;
        rec.block_index = r_count;
        rec.low_peak    = fold_min;
        rec.high_peak   = fold_max;
        rec.run_end     = i_last & ~i_above;
    end

    always_comb begin
        n_partial    = r_partial;
        n_min        = r_min;
        n_max        = r_max;
        n_count      = r_count;
        n_slot_valid = r_slot_valid & ~(sel & i_move);
        n_slot       = r_slot;
        if (i_accept) begin
            if (emit) begin
                n_slot_valid = 1'b1;
                n_slot       = rec;
            end
            if (i_last) begin
                n_partial = 1'b0;
                n_count   = '0;
            end else if (emit) begin
                n_partial = 1'b0;
                n_count   = r_count + 1'b1;
            end else begin
                n_partial = 1'b1;
                n_min     = fold_min;
                n_max     = fold_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial    <= 1'b0;
            r_count      <= '0;
            r_slot_valid <= 1'b0;
        end else begin
            r_partial    <= n_partial;
            r_count      <= n_count;
            r_slot_valid <= n_slot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_min  <= n_min;
        r_max  <= n_max;
        r_slot <= n_slot;
    end

    `MMPP_NEVER(a_slot_overrun, i_clk, i_rst_n,
        (i_accept && emit && r_slot_valid && !(sel && i_move)), "pending block overwritten")
    `MMPP_ASSERT(a_slot_order, i_clk, i_rst_n,
        (r_slot_valid && !sel |-> i_up.busy), "slot picked out of level order")
    `MMPP_ASSERT(a_last_clears, i_clk, i_rst_n,
        (i_accept && i_last |=> !r_partial && r_count == '0), "level not cleared at end")

endmodule

// ===== hw/rtl/multilevel_min_max_peak_pyramid.sv =====
`timescale 1ns / 1ps
`include "multilevel_min_max_peak_pyramid_defines.svh"

// Min/max peak pyramid over a stream of signed samples.
// Input channel: i_valid / o_stall with i_sample and i_stream_end; a request is
// taken on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with level, block index, low and high peak
// and run_end; one result per completed block, taken on the same kind of edge.
// One cell per level holds the running peaks, the block count and one pending
// result; all cells fold a sample in the same cycle.
// A result passes through the pending slot of its cell and then the output
// register before it shows on o_valid.
// Throughput: one sample per cycle while the receiver does not stall and
// each sample completes at most one block; a sample that completes more than
// one block holds the input while more than one result is pending, since the
// output port drains one pending result per cycle in ascending level order.
// i_stream_end flushes partial blocks up to the sample count, marks the last
// result with run_end and clears the sample count and every level.
// Reset clears the sample count, all levels, pending results and the output.
// While the receiver stalls the output holds; pending results stay in the
// cells and the input stalls once a new sample could overtake them.
module multilevel_min_max_peak_pyramid import mmpp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [SMP_W-1:0] i_sample,
    input  logic                    i_stream_end,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [LVL_W-1:0]        o_level,
    output logic [IDX_W-1:0]        o_block_index,
    output logic signed [SMP_W-1:0] o_low_peak,
    output logic signed [SMP_W-1:0] o_high_peak,
    output logic                    o_run_end
);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    t_rec             r_out, n_out;

    logic [CNT_W-1:0] cnt_new;
    logic             in_acc;
    logic             move;

    t_up              up    [LEVELS+1];
    logic [CNT_W-1:0] cnt   [LEVELS+1];
    logic             above [LEVELS+1];
    t_rec             pick  [LEVELS+1];

    assign cnt_new = (r_count == CNT_MAX) ? r_count : r_count + 1'b1;

    assign up[0]         = '{busy: 1'b0, extra: 1'b0, aligned: 1'b1};
    assign cnt[0]        = cnt_new;
    assign above[LEVELS] = 1'b0;
    assign pick[0]       = '0;

    genvar k;
    generate
        for (k = 0; k < LEVELS; k++) begin : g_cell
            mmpp_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_level  (LVL_W'(k + 1)),
                .i_accept (in_acc),
                .i_sample (i_sample),
                .i_last   (i_stream_end),
                .i_move   (move),
                .i_cnt    (cnt[k]),
                .o_cnt    (cnt[k+1]),
                .i_up     (up[k]),
                .o_up     (up[k+1]),
                .i_above  (above[k+1]),
                .o_above  (above[k]),
                .i_pick   (pick[k]),
                .o_pick   (pick[k+1])
            );
        end
    endgenerate

    always_comb begin
        move    = up[LEVELS].busy & (~r_out_valid | ~i_stall);
        o_stall = up[LEVELS].busy & ~(move & ~up[LEVELS].extra);
        in_acc  = i_valid & ~o_stall;

        n_count = r_count;
        if (in_acc) begin
            n_count = i_stream_end ? '0 : cnt_new;
        end

        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (move) begin
            n_out_valid = 1'b1;
            n_out       = pick[LEVELS];
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid       = r_out_valid;
    assign o_level       = r_out.level;
    assign o_block_index = r_out.block_index;
    assign o_low_peak    = r_out.low_peak;
    assign o_high_peak   = r_out.high_peak;
    assign o_run_end     = r_out.run_end;

    `MMPP_ASSERT(a_end_clears_count, i_clk, i_rst_n,
        (in_acc && i_stream_end |=> r_count == '0), "sample count not cleared at end")
    `MMPP_ASSERT(a_level_range, i_clk, i_rst_n,
        (o_valid |-> o_level >= LVL_W'(1) && o_level <= LVL_W'(LEVELS)), "level out of range")
    `MMPP_ASSERT(a_peak_order, i_clk, i_rst_n,
        (o_valid |-> o_low_peak <= o_high_peak), "low peak above high peak")
    `MMPP_ASSERT(a_pair_emits, i_clk, i_rst_n,
        (in_acc && !cnt_new[0] |=> up[LEVELS].busy), "completed pair left no result")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import mmpp_pkg::*;

    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int RANDOM_REQUESTS = 300;
    localparam int LONG_STREAM     = 140;
    localparam int RX_HOLD         = 400;
    localparam int PRINT_CAP       = 100;

    typedef logic signed [SMP_W-1:0] t_sample;

    localparam t_sample SMP_LO = {1'b1, {(SMP_W-1){1'b0}}};
    localparam t_sample SMP_HI = {1'b0, {(SMP_W-1){1'b1}}};

    typedef struct {
        int smp;
        int last;
        int typed;
        int n_want;
        int lvl;
        int idx;
        int lo;
        int hi;
        int re;
    } t_probe_row;

    t_probe_row probes [22] = '{
        '{ 32767, 0, 1, 0, 0, 0,      0,     0, 0},
        '{-32768, 0, 1, 1, 1, 0, -32768, 32767, 0},
        '{     0, 1, 1, 1, 1, 1,      0,     0, 1},
        '{    -1, 1, 1, 0, 0, 0,      0,     0, 0},
        '{   100, 0, 0, 0, 0, 0,      0,     0, 0},
        '{   200, 1, 1, 1, 1, 0,    100,   200, 1},
        '{-32768, 0, 0, 0, 0, 0,      0,     0, 0},
        '{ 32767, 0, 0, 0, 0, 0,      0,     0, 0},
        '{ 21845, 0, 0, 0, 0, 0,      0,     0, 0},
        '{-21846, 0, 0, 0, 0, 0,      0,     0, 0},
        '{     1, 0, 0, 0, 0, 0,      0,     0, 0},
        '{    -2, 0, 0, 0, 0, 0,      0,     0, 0},
        '{ 32766, 0, 0, 0, 0, 0,      0,     0, 0},
        '{    -3, 1, 0, 0, 0, 0,      0,     0, 0},
        '{     7, 0, 0, 0, 0, 0,      0,     0, 0},
        '{     7, 0, 0, 0, 0, 0,      0,     0, 0},
        '{     7, 0, 0, 0, 0, 0,      0,     0, 0},
        '{     7, 0, 0, 0, 0, 0,      0,     0, 0},
        '{    -7, 1, 0, 0, 0, 0,      0,     0, 0},
        '{     0, 0, 0, 0, 0, 0,      0,     0, 0},
        '{-32768, 0, 0, 0, 0, 0,      0,     0, 0},
        '{ 32767, 1, 1, 1, 1, 1,  32767, 32767, 1}
    };

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    t_sample          i_sample = '0;
    logic             i_stream_end = 1'b0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [LVL_W-1:0] o_level;
    logic [IDX_W-1:0] o_block_index;
    t_sample          o_low_peak;
    t_sample          o_high_peak;
    logic             o_run_end;

    logic [CNT_W-1:0] seen_count;
    t_sample          lvl_lo [LEVELS];
    t_sample          lvl_hi [LEVELS];
    bit               lvl_open [LEVELS];
    logic [IDX_W-1:0] lvl_blocks [LEVELS];
    t_rec             pending_peaks [$];

    int mismatches = 0;
    int cycle_count = 0;
    bit quick_idle = 1'b0;
    bit hold_rx_req = 1'b0;

    multilevel_min_max_peak_pyramid u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_stream_end  (i_stream_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_level       (o_level),
        .o_block_index (o_block_index),
        .o_low_peak    (o_low_peak),
        .o_high_peak   (o_high_peak),
        .o_run_end     (o_run_end)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void clear_pyramid();
        seen_count = '0;
        for (int lv = 0; lv < LEVELS; lv++) begin
            lvl_lo[lv]     = '0;
            lvl_hi[lv]     = '0;
            lvl_open[lv]   = 1'b0;
            lvl_blocks[lv] = '0;
        end
    endfunction

    function automatic int fold_sample(input t_sample smp, input logic last);
        bit             stepped;
        logic [CNT_W:0] span;
        logic [CNT_W:0] count_ext;
        t_rec           peak;
        int             n;
        n = 0;
        stepped = (seen_count != CNT_MAX);
        if (stepped) begin
            seen_count = seen_count + 1'b1;
        end
        count_ext = {1'b0, seen_count};
        for (int lv = 0; lv < LEVELS; lv++) begin
            span = {{CNT_W{1'b0}}, 1'b1} << (lv + 1);
            if (!lvl_open[lv]) begin
                lvl_lo[lv]   = smp;
                lvl_hi[lv]   = smp;
                lvl_open[lv] = 1'b1;
            end else begin
                if (smp < lvl_lo[lv]) lvl_lo[lv] = smp;
                if (smp > lvl_hi[lv]) lvl_hi[lv] = smp;
            end
            if ((stepped && (count_ext & (span - 1'b1)) == '0) ||
                (last && lvl_open[lv] && span <= count_ext)) begin
                peak.level       = LVL_W'(lv + 1);
                peak.block_index = lvl_blocks[lv];
                peak.low_peak    = lvl_lo[lv];
                peak.high_peak   = lvl_hi[lv];
                peak.run_end     = 1'b0;
                pending_peaks.push_back(peak);
                lvl_blocks[lv] = lvl_blocks[lv] + 1'b1;
                lvl_open[lv]   = 1'b0;
                n++;
            end
        end
        if (last) begin
            if (n > 0) begin
                peak = pending_peaks.pop_back();
                peak.run_end = 1'b1;
                pending_peaks.push_back(peak);
            end
            clear_pyramid();
        end
        return n;
    endfunction

    function automatic int pick_gap(input bit quick);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 93 || quick) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 9))
            0: return SMP_LO;
            1: return SMP_HI;
            2: return '0;
            3: return '1;
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("%0t peak mismatch: %s want %0d got %0d", $time, what, want, got);
        end
    endtask

    task automatic send_request(input t_sample smp, input logic last, input int gap,
                                output int made);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid      <= 1'b0;
            i_sample     <= t_sample'($urandom);
            i_stream_end <= 1'($urandom);
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_sample     <= smp;
        i_stream_end <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        made = fold_sample(smp, last);
    endtask

    always @(posedge i_clk) begin
        t_rec want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_peaks.size() == 0) begin
                report_mismatch("result with none pending, level", 0, o_level);
            end else begin
                want = pending_peaks.pop_front();
                if (o_level !== want.level)
                    report_mismatch("level", want.level, o_level);
                if (o_block_index !== want.block_index)
                    report_mismatch("block_index", want.block_index, o_block_index);
                if (o_low_peak !== want.low_peak)
                    report_mismatch("low_peak", want.low_peak, o_low_peak);
                if (o_high_peak !== want.high_peak)
                    report_mismatch("high_peak", want.high_peak, o_high_peak);
                if (o_run_end !== want.run_end)
                    report_mismatch("run_end", want.run_end, o_run_end);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        int stall_left;
        int free_left;
        stall_left = 0;
        free_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_rx_req) begin
                hold_rx_req = 1'b0;
                i_stall <= 1'b1;
                repeat (RX_HOLD) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
                if (free_left > 0) begin
                    free_left--;
                end else if ($urandom_range(0, 15) == 0) begin
                    free_left = 60;
                end else begin
                    stall_left = pick_gap(quick_idle);
                end
            end
        end
    end

    initial begin
        int      made;
        int      sent;
        int      len;
        int      roll;
        bit      gapless;
        bit      narrow;
        t_sample base;
        t_sample smp;
        t_rec    want;

        clear_pyramid();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probes[r]) begin
            send_request(t_sample'(probes[r].smp), probes[r].last != 0, pick_gap(1'b0), made);
            if (probes[r].typed != 0) begin
                repeat (made) void'(pending_peaks.pop_back());
                if (probes[r].n_want > 0) begin
                    want.level       = LVL_W'(probes[r].lvl);
                    want.block_index = IDX_W'(probes[r].idx);
                    want.low_peak    = t_sample'(probes[r].lo);
                    want.high_peak   = t_sample'(probes[r].hi);
                    want.run_end     = probes[r].re != 0;
                    pending_peaks.push_back(want);
                end
            end
        end

        // hold the source until the pyramid has drained
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_peaks.size() != 0) @(posedge i_clk);

        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            roll = $urandom_range(0, 19);
            if (roll < 3) len = $urandom_range(1, 3);
            else if (roll < 17) len = $urandom_range(4, 40);
            else len = $urandom_range(41, 140);
            if (len > RANDOM_REQUESTS - sent) len = RANDOM_REQUESTS - sent;
            gapless = ($urandom_range(0, 3) == 0);
            narrow  = ($urandom_range(0, 4) == 0);
            base    = pick_sample();
            for (int k = 0; k < len; k++) begin
                if (sent == 60) hold_rx_req = 1'b1;
                smp = narrow ? base + t_sample'($urandom_range(0, 3)) : pick_sample();
                send_request(smp, k == len - 1, gapless ? 0 : pick_gap(1'b0), made);
                sent++;
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_peaks.size() != 0) @(posedge i_clk);

        // one longer stream to close and flush blocks on the upper levels
        quick_idle = 1'b1;
        for (int k = 0; k < LONG_STREAM; k++) begin
            send_request(pick_sample(), k == LONG_STREAM - 1, pick_gap(1'b1), made);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (pending_peaks.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
